/* rtl/rtp_h264_depacketizer_unit_macros.svh */
// Assertion macros shared by the depacketizer checker.
`ifndef RTP_H264_DEPACKETIZER_UNIT_MACROS_SVH
`define RTP_H264_DEPACKETIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RTPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RTPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rtph264_pkg.sv */
// Types and constants shared by the RTP H.264 depacketizer modules.
package rtph264_pkg;

  localparam int HEADER_BYTES = 12;
  localparam logic [31:0] WRAP_CORNER_RESET = 32'd10000;

  // NAL unit types.
  localparam logic [4:0] NAL_SLICE     = 5'd1;
  localparam logic [4:0] NAL_IDR       = 5'd5;
  localparam logic [4:0] NAL_SEI       = 5'd6;
  localparam logic [4:0] NAL_SPS       = 5'd7;
  localparam logic [4:0] NAL_PPS       = 5'd8;
  localparam logic [4:0] NAL_FU_A      = 5'd28;

  // Result kinds.
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_MARKER   = 2'd1;
  localparam logic [1:0] KIND_REJECT   = 2'd2;

  // Reject reasons.
  localparam logic [1:0] REASON_NONE   = 2'd0;
  localparam logic [1:0] REASON_SHORT  = 2'd1;
  localparam logic [1:0] REASON_LATE   = 2'd2;

  // Bit positions in a command's result mask, in emission order.
  localparam int MB_MARKER = 0;
  localparam int MB_REJECT = 1;
  localparam int MB_START0 = 2;
  localparam int MB_START3 = 5;
  localparam int MB_D0     = 6;
  localparam int MB_D1     = 7;
  localparam int MASK_W    = 8;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_PASS    = 2'd1,
    MODE_DISCARD = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  reject_reason;
    logic [31:0] frame_timestamp;
    logic [31:0] frame_ssrc;
    logic        last;
  } out_item_t;

  // One classified input byte: which results it causes and their payload.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [31:0]       ts;
    logic [31:0]       ssrc;
    logic [1:0]        reason;
    logic [7:0]        d0;
    logic [7:0]        d1;
  } cmd_t;

endpackage

/* rtl/rtph264_cmd_queue.sv */
// Short command queue between the classifying front end and the output back end.
module rtph264_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rtph264_pkg::cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output rtph264_pkg::cmd_t  pop_cmd,
  output logic               empty
);
  import rtph264_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/rtph264_front.sv */
// Front end: parses the RTP header, tracks the frame and classifies each byte.
module rtph264_front #(
  parameter int MAX_PACKET_BYTES = 65535
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           wrap_corner,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rtph264_pkg::in_item_t in_data,
  input  logic                  q_full,
  output logic                  push,
  output rtph264_pkg::cmd_t     push_cmd
);
  import rtph264_pkg::*;

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      pts_r, pts_nxt;
  logic [31:0]      pss_r, pss_nxt;
  logic [31:0]      fts_r, fts_nxt;
  logic [31:0]      fss_r, fss_nxt;
  logic             fe_r, fe_nxt;
  logic [7:0]       held_r, held_nxt;
  mode_t            mode_r, mode_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        eop;
  logic        in_hdr;
  logic        at_decide;
  logic        deciding;
  logic [31:0] ft;
  logic [31:0] fs;
  logic        newer;
  logic        late;
  logic [4:0]  ntype;
  logic        single;
  logic        fua;
  logic        fua_start;
  cmd_t        cmd;

  assign in_ready  = !q_full;
  assign accept    = in_valid && !q_full;
  assign b         = in_data.packet_byte;
  assign eop       = in_data.packet_end;
  assign in_hdr    = (mode_r == MODE_HEADER);
  assign at_decide = (pos_r >= POS_W'(HEADER_BYTES + 1));
  assign deciding  = in_hdr && at_decide;

  // An empty frame adopts the packet's timestamp, so it is never newer or late.
  assign ft    = fe_r ? pts_r : fts_r;
  assign fs    = fe_r ? pss_r : fss_r;
  assign newer = (ft < pts_r) || ((ft > wrap_corner) && (pts_r < wrap_corner));
  assign late  = !newer && (ft != pts_r);

  assign ntype  = held_r[4:0];
  assign single = (ntype == NAL_SLICE) || (ntype == NAL_IDR) || (ntype == NAL_SEI) ||
                  (ntype == NAL_SPS) || (ntype == NAL_PPS);
  assign fua       = (ntype == NAL_FU_A);
  assign fua_start = fua && b[7];

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      if (eop) begin
        mode_nxt = MODE_HEADER;
      end else if (deciding) begin
        if (late) begin
          mode_nxt = MODE_DISCARD;
        end else if (single || fua) begin
          mode_nxt = MODE_PASS;
        end else begin
          mode_nxt = MODE_DISCARD;
        end
      end
    end
  end

  // Command for the back end.
  always_comb begin
    cmd = '0;
    unique case (mode_r)
      MODE_HEADER: begin
        if (!at_decide) begin
          if (eop) begin
            cmd.mask[MB_REJECT] = 1'b1;
            cmd.reason          = REASON_SHORT;
          end
        end else begin
          if (newer) begin
            cmd.mask[MB_MARKER] = 1'b1;
            cmd.ts              = ft;
            cmd.ssrc            = fs;
          end
          if (late) begin
            cmd.mask[MB_REJECT] = 1'b1;
            cmd.reason          = REASON_LATE;
          end else if (single) begin
            cmd.mask[MB_D1:MB_START0] = '1;
            cmd.d0                    = held_r;
            cmd.d1                    = b;
          end else if (fua_start) begin
            cmd.mask[MB_D0:MB_START0] = '1;
            cmd.d0                    = {held_r[7:5], b[4:0]};
          end
        end
      end
      MODE_PASS: begin
        cmd.mask[MB_D0] = 1'b1;
        cmd.d0          = b;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign push     = accept && (cmd.mask != '0);
  assign push_cmd = cmd;

  // Header capture and frame tracking.
  always_comb begin
    pos_nxt  = pos_r;
    pts_nxt  = pts_r;
    pss_nxt  = pss_r;
    fts_nxt  = fts_r;
    fss_nxt  = fss_r;
    fe_nxt   = fe_r;
    held_nxt = held_r;
    if (accept) begin
      if (in_hdr) begin
        if (pos_r >= POS_W'(4) && pos_r <= POS_W'(7)) begin
          pts_nxt = {pts_r[23:0], b};
        end else if (pos_r >= POS_W'(8) && pos_r < POS_W'(HEADER_BYTES)) begin
          pss_nxt = {pss_r[23:0], b};
        end else if (pos_r == POS_W'(HEADER_BYTES)) begin
          held_nxt = b;
        end
      end
      if (deciding) begin
        if (fe_r || newer) begin
          fts_nxt = pts_r;
          fss_nxt = pss_r;
        end
        if (!late && (single || fua_start)) begin
          fe_nxt = 1'b0;
        end else if (newer) begin
          fe_nxt = 1'b1;
        end
      end else if (mode_r == MODE_PASS) begin
        fe_nxt = 1'b0;
      end
      if (eop) begin
        pos_nxt = '0;
      end else if (pos_r < POS_W'(MAX_PACKET_BYTES)) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pts_r  <= '0;
      pss_r  <= '0;
      fts_r  <= '0;
      fss_r  <= '0;
      fe_r   <= 1'b1;
      held_r <= '0;
      mode_r <= MODE_HEADER;
    end else begin
      pos_r  <= pos_nxt;
      pts_r  <= pts_nxt;
      pss_r  <= pss_nxt;
      fts_r  <= fts_nxt;
      fss_r  <= fss_nxt;
      fe_r   <= fe_nxt;
      held_r <= held_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

/* rtl/rtph264_back.sv */
// Back end: expands commands into results, one per unstalled cycle, into an output register.
module rtph264_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  rtph264_pkg::cmd_t      q_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rtph264_pkg::out_item_t out_data
);
  import rtph264_pkg::*;

  logic              cur_valid_r, cur_valid_nxt;
  cmd_t              cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [MASK_W-1:0] lowbit;
  logic [MASK_W-1:0] rest;
  logic              emit;
  out_item_t         item;

  assign lowbit = cur_r.mask & (~cur_r.mask + 1'b1);
  assign rest   = cur_r.mask & ~lowbit;
  assign emit   = cur_valid_r && (!out_valid_r || out_ready);
  assign pop    = !q_empty && (!cur_valid_r || (emit && (rest == '0)));

  // The lowest pending mask bit is the next result.
  always_comb begin
    item      = '0;
    item.kind = KIND_DATA;
    item.last = (rest == '0);
    priority if (lowbit[MB_MARKER]) begin
      item.kind            = KIND_MARKER;
      item.frame_timestamp = cur_r.ts;
      item.frame_ssrc      = cur_r.ssrc;
    end else if (lowbit[MB_REJECT]) begin
      item.kind          = KIND_REJECT;
      item.reject_reason = cur_r.reason;
    end else if (lowbit[MB_START3]) begin
      item.data_byte = 8'd1;
    end else if (lowbit[MB_D0]) begin
      item.data_byte = cur_r.d0;
    end else if (lowbit[MB_D1]) begin
      item.data_byte = cur_r.d1;
    end else begin
      item.data_byte = 8'd0;
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_cmd;
    end else if (emit) begin
      cur_nxt.mask  = rest;
      cur_valid_nxt = (rest != '0);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/rtp_h264_depacketizer_unit.sv */
// The first result of a byte goes through the queue, current-command and output registers.
// Throughput: one packet byte per cycle while the queue has room; results leave at one
// per cycle while out_ready is high, so a byte with k results (start code bursts, up to
// seven) holds the output for all k; the queue absorbs the difference until it fills.
// Reset (rst_n low, synchronous): frame empty, header phase, queue and output cleared,
// wrap corner back to 10000.
module rtp_h264_depacketizer_unit #(
  parameter int MAX_PACKET_BYTES = 65535,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_wrap_corner,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rtph264_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rtph264_pkg::out_item_t out_data
);
  import rtph264_pkg::*;

  // The wrap corner register is written whenever a configuration transfer
  // occurs; the port never stalls.
  logic [31:0] wrap_corner_r;

  // Front end to queue.
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;

  // Queue to back end.
  logic q_pop;
  cmd_t q_pop_cmd;
  logic q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_corner_r <= WRAP_CORNER_RESET;
    end else if (cfg_valid) begin
      wrap_corner_r <= cfg_wrap_corner;
    end
  end

  // The front end takes one byte per cycle while the queue has room. It
  // collects the header fields, decides at the byte after the NAL header
  // whether the packet is short, late or starts a new frame, and turns each
  // byte that causes any result into one command listing every result it causes.
  rtph264_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .wrap_corner(wrap_corner_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (q_push),
    .push_cmd   (q_push_cmd)
  );

  // Commands wait here so that a start code burst on the output does not
  // immediately stall the input.
  rtph264_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .pop_cmd (q_pop_cmd),
    .empty   (q_empty)
  );

  // The back end walks each command's result mask in order and loads one
  // result per cycle, while the output is not stalled, into the output
  // register, marking the final one of each command as last.
  rtph264_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (q_pop_cmd),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

/* rtl/rtph264_checker.sv */
// Port-level checker for the depacketizer and its bind to the top level.
`include "rtp_h264_depacketizer_unit_macros.svh"

module rtph264_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input rtph264_pkg::out_item_t out_data
);
  import rtph264_pkg::*;

  logic stalled;
  logic non_data;
  logic is_reject;
  logic not_reject;
  logic reason_none;
  logic reject_clean;

  assign stalled      = out_valid && !out_ready;
  assign non_data     = out_valid && (out_data.kind != KIND_DATA);
  assign is_reject    = out_valid && (out_data.kind == KIND_REJECT);
  assign not_reject   = out_valid && (out_data.kind != KIND_REJECT);
  assign reason_none  = (out_data.reject_reason == REASON_NONE);
  // A reject carries a reason and no frame fields.
  assign reject_clean = !reason_none && (out_data.frame_timestamp == 32'd0) &&
                        (out_data.frame_ssrc == 32'd0);

  `RTPH_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(out_data), "stalled result changed")
  `RTPH_ASSERT_IMP(a_data_zero, non_data, out_data.data_byte == 8'd0, "data byte on a non-data result")
  `RTPH_ASSERT_IMP(a_reject_fields, is_reject, reject_clean, "reject result has bad fields")
  `RTPH_ASSERT_IMP(a_reason_only_reject, not_reject, reason_none, "reason on a non-reject result")

endmodule

bind rtp_h264_depacketizer_unit rtph264_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
